/* hw/rtl/chbm_pkg.sv */
// Shared types, constants and the popcount function of the census best-match block.
package chbm_pkg;

    localparam int SAMPLE_COUNT = 16;
    localparam int WORD_BITS = 16;
    localparam int IDX_W = 16;
    localparam int SUM_CAP = WORD_BITS * SAMPLE_COUNT;
    localparam int SUM_W = $clog2(SUM_CAP + 1);
    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int NIB_COUNT = WORD_BITS / 4;
    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] MATCH_LIMIT_RESET = LIMIT_W'(257);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] left_census;
        logic [WORD_BITS-1:0] right_census;
        logic [IDX_W-1:0]     query_index;
        logic [IDX_W-1:0]     candidate_index;
        logic                 last_word;
        logic                 last_candidate;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] matched_query;
        logic [IDX_W-1:0] best_candidate;
        logic [SUM_W-1:0] best_distance;
        logic             accepted;
    } out_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] pop_count;
        logic [IDX_W-1:0] query_index;
        logic [IDX_W-1:0] candidate_index;
        logic             last_word;
        logic             last_candidate;
    } mid_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [2:0]       nib [NIB_COUNT];
        logic [CNT_W-1:0] total;
        for (int j = 0; j < NIB_COUNT; j++)
        begin
            nib[j] = 3'(v[4*j]) + 3'(v[4*j+1]) + 3'(v[4*j+2]) + 3'(v[4*j+3]);
        end
        total = '0;
        for (int j = 0; j < NIB_COUNT; j++)
        begin
            total = total + CNT_W'(nib[j]);
        end
        return total;
    endfunction

endpackage

/* hw/rtl/census_hamming_best_match.sv */
// Top level of the census Hamming best-match search.
//
//   channel   direction  handshake               word
//   in_word   in         push / full             one census pair with indexes and marks
//   out_word  out        pop / empty             query, best candidate, distance, accepted
//   cfg       in         cfg_valid / cfg_ready   match limit
//
// One word per cycle unless full or a waiting result holds the flow: the popcount forms as a word
// enters the four-entry queue, and the back end adds, saturates and compares as it pops the word.
// A result is registered and reaches out_word once the back end takes its final word from the queue.
// Words that make no result keep flowing while a result waits; one that would make another
// result stays at the head, and full rises once the queue holds four words.
// Reset empties the queue, drops any result and search state, and sets the match limit to 257.
module census_hamming_best_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  chbm_pkg::in_word_t            in_word,
    output logic                          empty,
    input  logic                          pop,
    output chbm_pkg::out_word_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [chbm_pkg::LIMIT_W-1:0]  cfg_data
);
    import chbm_pkg::*;

    logic [LIMIT_W-1:0] match_limit_reg, match_limit_next;
    q_stat_t            q_stat;
    logic               q_push;
    logic               q_pop;
    mid_word_t          q_in;
    mid_word_t          q_out;

    assign cfg_ready        = 1'b1;
    assign match_limit_next = (cfg_valid && cfg_ready) ? cfg_data : match_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_limit_reg <= MATCH_LIMIT_RESET;
        end
        else
        begin
            match_limit_reg <= match_limit_next;
        end
    end

    chbm_front u_front (
        .push    (push),
        .full    (full),
        .in_word (in_word),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    chbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    chbm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .match_limit (match_limit_reg),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word)
    );

endmodule

/* hw/rtl/chbm_front.sv */
// Front end: accepts census word pairs and reduces each to its XOR popcount.
module chbm_front (
    input  logic                push,
    output logic                full,
    input  chbm_pkg::in_word_t  in_word,
    input  chbm_pkg::q_stat_t   q_stat,
    output logic                q_push,
    output chbm_pkg::mid_word_t q_data
);
    import chbm_pkg::*;

    assign full   = q_stat.full;
    assign q_push = push && !q_stat.full;

    always_comb
    begin
        q_data.pop_count       = popcount(in_word.left_census ^ in_word.right_census);
        q_data.query_index     = in_word.query_index;
        q_data.candidate_index = in_word.candidate_index;
        q_data.last_word       = in_word.last_word;
        q_data.last_candidate  = in_word.last_candidate;
    end

endmodule

/* hw/rtl/chbm_queue.sv */
// Short queue of classified words between the front and back ends.
module chbm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  chbm_pkg::mid_word_t push_data,
    input  logic                pop,
    output chbm_pkg::mid_word_t pop_data,
    output chbm_pkg::q_stat_t   stat
);
    import chbm_pkg::*;

    mid_word_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("Queue read while empty.");
`endif

endmodule

/* hw/rtl/chbm_back.sv */
// Back end: accumulates distances, tracks the best candidate and holds the result word.
module chbm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chbm_pkg::q_stat_t             q_stat,
    input  chbm_pkg::mid_word_t           q_data,
    output logic                          q_pop,
    input  logic [chbm_pkg::LIMIT_W-1:0]  match_limit,
    output logic                          empty,
    input  logic                          pop,
    output chbm_pkg::out_word_t           out_word
);
    import chbm_pkg::*;

    logic [SUM_W-1:0] running_sum_reg, running_sum_next;
    logic             lowest_set_reg, lowest_set_next;
    logic [SUM_W-1:0] lowest_sum_reg, lowest_sum_next;
    logic [IDX_W-1:0] lowest_index_reg, lowest_index_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg, out_word_next;

    logic [SUM_W:0]   sum_raw;
    logic [SUM_W-1:0] sum_cap;
    logic             emit_now;
    logic             take_out;
    logic             better;
    logic [SUM_W-1:0] final_sum;
    logic [IDX_W-1:0] final_index;

    assign take_out = pop && out_valid_reg;
    assign emit_now = q_data.last_word && q_data.last_candidate;
    assign q_pop    = !q_stat.empty && (!out_valid_reg || take_out || !emit_now);

    assign sum_raw = {1'b0, running_sum_reg} + (SUM_W + 1)'(q_data.pop_count);
    assign sum_cap = (sum_raw > (SUM_W + 1)'(SUM_CAP)) ? SUM_W'(SUM_CAP) : sum_raw[SUM_W-1:0];
    assign better  = !lowest_set_reg || (sum_cap < lowest_sum_reg);

    assign final_sum   = better ? sum_cap : lowest_sum_reg;
    assign final_index = better ? q_data.candidate_index : lowest_index_reg;

    always_comb
    begin
        running_sum_next  = running_sum_reg;
        lowest_set_next   = lowest_set_reg;
        lowest_sum_next   = lowest_sum_reg;
        lowest_index_next = lowest_index_reg;
        out_valid_next    = take_out ? 1'b0 : out_valid_reg;
        out_word_next     = out_word_reg;
        if (q_pop)
        begin
            if (!q_data.last_word)
            begin
                running_sum_next = sum_cap;
            end
            else
            begin
                running_sum_next = '0;
                if (q_data.last_candidate)
                begin
                    lowest_set_next              = 1'b0;
                    out_valid_next               = 1'b1;
                    out_word_next.matched_query  = q_data.query_index;
                    out_word_next.best_candidate = final_index;
                    out_word_next.best_distance  = final_sum;
                    out_word_next.accepted       = (LIMIT_W'(final_sum) < match_limit);
                end
                else
                begin
                    lowest_set_next   = 1'b1;
                    lowest_sum_next   = final_sum;
                    lowest_index_next = final_index;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            lowest_set_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            lowest_set_reg  <= lowest_set_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lowest_sum_reg   <= lowest_sum_next;
        lowest_index_reg <= lowest_index_next;
        out_word_reg     <= out_word_next;
    end

    assign empty    = !out_valid_reg;
    assign out_word = out_word_reg;

`ifndef SYNTHESIS
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_sum_reg <= SUM_W'(SUM_CAP))
        else $error("Running sum above its saturation value.");
    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.best_distance <= SUM_W'(SUM_CAP)))
        else $error("Result distance above its saturation value.");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("Waiting result word changed before it was popped.");
`endif

endmodule
